// ===== hw/rtl/tte_pkg.sv =====
// Package for the tabbed text extent block: field widths, control byte codes,
// register indexes and reset values, and a saturating helper.
// No dependencies; compile before every other file of the block.
`default_nettype none

package tte_pkg;

  localparam int unsigned TTE_BYTE_W = 8;
  localparam int unsigned TTE_POS_W  = 16;
  localparam int unsigned TTE_CFG_IW = 2;
  localparam int unsigned TTE_TAB_STOP_CHARS = 8;

  // Control bytes decoded by the pen tracking.
  localparam logic [TTE_BYTE_W-1:0] CH_NUL = 8'h00;
  localparam logic [TTE_BYTE_W-1:0] CH_BEL = 8'h07;
  localparam logic [TTE_BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [TTE_BYTE_W-1:0] CH_TAB = 8'h09;
  localparam logic [TTE_BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [TTE_BYTE_W-1:0] CH_VT  = 8'h0B;
  localparam logic [TTE_BYTE_W-1:0] CH_CR  = 8'h0D;

  // Configuration register indexes.
  localparam logic [TTE_CFG_IW-1:0] REG_CHAR_WIDTH      = 2'd0;
  localparam logic [TTE_CFG_IW-1:0] REG_WIDE_CHAR_WIDTH = 2'd1;
  localparam logic [TTE_CFG_IW-1:0] REG_CHAR_HEIGHT     = 2'd2;

  localparam logic [TTE_BYTE_W-1:0] RST_CHAR_WIDTH      = 8'd8;
  localparam logic [TTE_BYTE_W-1:0] RST_WIDE_CHAR_WIDTH = 8'd0;
  localparam logic [TTE_BYTE_W-1:0] RST_CHAR_HEIGHT     = 8'd16;

  // Clamp a 17-bit sum to the 16-bit position range.
  function automatic logic [TTE_POS_W-1:0] tte_sat(input logic [TTE_POS_W:0] s);
    return s[TTE_POS_W] ? {TTE_POS_W{1'b1}} : s[TTE_POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tte_if.sv =====
// Handshake interfaces of the tabbed text extent block: the byte channel and
// the extent result channel. Depends on tte_pkg for the field widths.
`default_nettype none

interface tte_in_if import tte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TTE_BYTE_W-1:0] text_byte;
  logic                  is_last;

  modport source (output valid, text_byte, is_last, input ready);
  modport sink   (input valid, text_byte, is_last, output ready);
endinterface

interface tte_out_if import tte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TTE_POS_W-1:0] extent_width;
  logic [TTE_POS_W-1:0] extent_height;

  modport source (output valid, extent_width, extent_height, input ready);
  modport sink   (input valid, extent_width, extent_height, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tabbed_text_extent.sv =====
// Top level of the tabbed text extent block: pen tracking, a bit-serial tab
// divider under a small sequencer, and the result register.
// Depends on tte_pkg and the interfaces in tte_if.sv.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+--------------------------------
//  in_ch    | in  | valid/ready        | text_byte[7:0], is_last
//  out_ch   | out | valid/ready        | extent_width[15:0], extent_height[15:0]
//  cfg      | in  | cfg_we, no wait    | cfg_index[1:0], cfg_wdata[7:0]
//
// An ordinary byte is handled as it is taken; a last byte then goes on to load
// the result register. A tab is taken, then runs 16 steps of the restoring
// divider (one quotient bit each), one multiply and one add.
// Reset is synchronous and active low; it clears the pen, the extent, the
// sequencer and the result valid flag, and loads the register defaults.
// The input is held off while a tab is divided, multiplied out and added, and
// while a finished extent waits for the result register to empty.
`default_nettype none

module tabbed_text_extent import tte_pkg::*; #(
  parameter int unsigned TAB_STOP_CHARS = TTE_TAB_STOP_CHARS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tte_in_if.sink                     in_ch,
  tte_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [TTE_CFG_IW-1:0] cfg_index,
  input  wire logic [TTE_BYTE_W-1:0] cfg_wdata
);

  localparam int unsigned MW = $clog2(TAB_STOP_CHARS + 1);
  localparam int unsigned PW = MW + TTE_BYTE_W;
  localparam logic [MW-1:0] TAB_N = MW'(TAB_STOP_CHARS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [TTE_BYTE_W-1:0] cw_r, wcw_r, ch_r;

  logic [TTE_POS_W-1:0] pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic [TTE_POS_W-1:0] max_x_r, max_x_nxt, max_y_r, max_y_nxt;
  logic                 lead_r, lead_nxt;
  logic                 last_r, last_nxt;

  // Divider and tab-stop arithmetic.
  logic [TTE_POS_W-1:0]  dvd_r, dvd_nxt;
  logic [TTE_BYTE_W-1:0] rem_r, rem_nxt;
  logic [MW-1:0]         tab_m_r, tab_m_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;

  logic                  out_valid_r;
  logic [TTE_POS_W-1:0]  out_w_r, out_h_r;

  logic                  in_acc, emit_go, hb, consumed;
  logic [TTE_BYTE_W-1:0] pend_w;
  logic [TTE_POS_W-1:0]  x1, mx1, x2, mx2, bs_x, y_adv, my_adv, xt, mxt;
  logic [TTE_BYTE_W:0]   div_try, div_d;
  logic                  div_ge;
  logic [MW:0]           m2;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign emit_go       = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.extent_width  = out_w_r;
  assign out_ch.extent_height = out_h_r;

  // A pending lead resolves first; a high byte pairs with it, others then act.
  assign hb       = in_ch.text_byte[TTE_BYTE_W-1];
  assign consumed = lead_r && hb;
  assign pend_w   = hb ? wcw_r : cw_r;
  assign x1  = lead_r ? tte_sat({1'b0, pen_x_r} + {9'b0, pend_w}) : pen_x_r;
  assign mx1 = (x1 > max_x_r) ? x1 : max_x_r;
  assign x2  = tte_sat({1'b0, x1} + {9'b0, cw_r});
  assign mx2 = (x2 > mx1) ? x2 : mx1;
  assign bs_x = (x1 > {8'b0, cw_r}) ? (x1 - {8'b0, cw_r}) : '0;
  assign y_adv  = tte_sat({1'b0, pen_y_r} + {9'b0, ch_r});
  assign my_adv = (y_adv > max_y_r) ? y_adv : max_y_r;

  // One restoring step; the quotient bit also folds into the tab-stop index.
  assign div_try = {rem_r, dvd_r[TTE_POS_W-1]};
  assign div_d   = div_try - {1'b0, cw_r};
  assign div_ge  = (div_try >= {1'b0, cw_r});
  assign m2      = {tab_m_r, div_ge};

  assign xt  = tte_sat({1'b0, pen_x_r} + (TTE_POS_W+1)'(prod_r));
  assign mxt = (xt > max_x_r) ? xt : max_x_r;

  always_comb begin
    state_nxt = state_r;
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    max_x_nxt = max_x_r;
    max_y_nxt = max_y_r;
    lead_nxt  = lead_r;
    last_nxt  = last_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    tab_m_nxt = tab_m_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pen_x_nxt = x1;
          max_x_nxt = mx1;
          lead_nxt  = 1'b0;
          last_nxt  = in_ch.is_last;
          if (in_ch.is_last) begin
            state_nxt = S_EMIT;
          end
          if (!consumed) begin
            if (hb) begin
              if (in_ch.is_last) begin
                pen_x_nxt = x2;
                max_x_nxt = mx2;
              end else begin
                lead_nxt = 1'b1;
              end
            end else begin
              unique case (in_ch.text_byte)
                CH_NUL, CH_BEL: begin
                end
                CH_BS: begin
                  pen_x_nxt = bs_x;
                end
                CH_LF: begin
                  pen_y_nxt = y_adv;
                  max_y_nxt = my_adv;
                  pen_x_nxt = '0;
                end
                CH_CR: begin
                  pen_x_nxt = '0;
                end
                CH_VT: begin
                  pen_y_nxt = y_adv;
                  max_y_nxt = my_adv;
                end
                CH_TAB: begin
                  if (cw_r != '0) begin
                    dvd_nxt   = x1;
                    rem_nxt   = '0;
                    tab_m_nxt = '0;
                    cnt_nxt   = '0;
                    state_nxt = S_DIV;
                  end
                end
                default: begin
                  pen_x_nxt = x2;
                  max_x_nxt = mx2;
                end
              endcase
            end
          end
        end
      end
      S_DIV: begin
        dvd_nxt   = {dvd_r[TTE_POS_W-2:0], 1'b0};
        rem_nxt   = div_ge ? div_d[TTE_BYTE_W-1:0] : div_try[TTE_BYTE_W-1:0];
        tab_m_nxt = (m2 >= {1'b0, TAB_N}) ? MW'(m2 - {1'b0, TAB_N}) : m2[MW-1:0];
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = {{TTE_BYTE_W{1'b0}}, TAB_N - tab_m_r} * {{MW{1'b0}}, cw_r};
        state_nxt = S_ADD;
      end
      S_ADD: begin
        pen_x_nxt = xt;
        max_x_nxt = mxt;
        state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_go) begin
          pen_x_nxt = '0;
          pen_y_nxt = '0;
          max_x_nxt = '0;
          max_y_nxt = '0;
          lead_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pen_x_r <= '0;
      pen_y_r <= '0;
      max_x_r <= '0;
      max_y_r <= '0;
      lead_r  <= 1'b0;
      last_r  <= 1'b0;
      tab_m_r <= '0;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      max_x_r <= max_x_nxt;
      max_y_r <= max_y_nxt;
      lead_r  <= lead_nxt;
      last_r  <= last_nxt;
      tab_m_r <= tab_m_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= RST_CHAR_WIDTH;
      wcw_r <= RST_WIDE_CHAR_WIDTH;
      ch_r  <= RST_CHAR_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHAR_WIDTH:      cw_r  <= cfg_wdata;
        REG_WIDE_CHAR_WIDTH: wcw_r <= cfg_wdata;
        REG_CHAR_HEIGHT:     ch_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Result register: a finished extent moves in only when the slot is free or emptying.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_w_r <= max_x_r;
      out_h_r <= max_y_r;
    end
  end

  a_pen_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
    (pen_x_r <= max_x_r) && (pen_y_r <= max_y_r))
    else $error("pen position lies outside the recorded extent");

  a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < cw_r))
    else $error("divider remainder not below the char width");

  a_tab_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    tab_m_r < TAB_N)
    else $error("tab-stop index out of range");

  a_last_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.is_last) |=> !lead_r)
    else $error("lead byte left pending after the last byte");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (max_x_r == '0) && (max_y_r == '0) && out_valid_r)
    else $error("extent not cleared or result not loaded after emit");

endmodule

`default_nettype wire
